[hw/rtl/adjacency_matrix_engine_top_defines.svh]
// Assertion macros shared by the adjacency matrix engine RTL.
`ifndef ADJACENCY_MATRIX_ENGINE_TOP_DEFINES_SVH
`define ADJACENCY_MATRIX_ENGINE_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define AME_ASSERT_SAME(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define AME_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

[hw/rtl/ame_pkg.sv]
// Types and constants of the adjacency matrix engine.
package ame_pkg;

   localparam int CMD_W       = 3;
   localparam int VTX_W       = 4;
   localparam int SVTX_W      = 5;
   localparam int WEIGHT_W    = 16;
   localparam int COUNT_W     = 9;
   localparam int VCNT_W      = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int RES_CNT_W   = 5;
   localparam int RESULT_LIMIT = 16;
   localparam int COUNT_MAX   = 511;
   localparam logic [VCNT_W-1:0] VCNT_RESET = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTED     = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_READ   = 3'd2,
      CMD_NEXT   = 3'd3,
      CMD_LIST   = 3'd4,
      CMD_COUNT  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MIRROR,
      ST_READ,
      ST_SCAN,
      ST_FLUSH,
      ST_COUNT
   } state_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight_out;
      logic                       is_adjacent;
      logic [VTX_W-1:0]           found_vertex;
      logic                       found;
      logic [COUNT_W-1:0]         edge_count;
      logic                       last_result;
   } rsp_type;

endpackage

[hw/rtl/adjacency_matrix_engine_top.sv]
// Adjacency matrix engine: weights in one memory, commands run by a sequencer.
// After reset a clearing pass writes MAX_VERTICES*MAX_VERTICES entries, one per cycle, busy high.
// Add, remove, unused codes: result in the cycle after accept; undirected writes hold busy while
// the mirror entry is written. Read edge: registered read, then registered result. Next neighbour
// and list: one entry read per cycle; count reads n*n entries. One command in flight; busy low once
// its results are out. Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
module adjacency_matrix_engine_top import ame_pkg::*; #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [CMD_W-1:0]             req_command,
   input  logic [VTX_W-1:0]             req_first_vertex,
   input  logic signed [SVTX_W-1:0]     req_second_vertex,
   input  logic signed [WEIGHT_W-1:0]   req_edge_weight,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   output logic                         rsp_valid,
   output logic signed [WEIGHT_W-1:0]   rsp_weight_out,
   output logic                         rsp_is_adjacent,
   output logic [VTX_W-1:0]             rsp_found_vertex,
   output logic                         rsp_found,
   output logic [COUNT_W-1:0]           rsp_edge_count,
   output logic                         rsp_last_result
);

   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);

   logic [VCNT_W-1:0]          vertex_count_ff;
   logic                       directed_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic signed [WEIGHT_W-1:0] mem_wdata;
   logic [AW-1:0]              mem_raddr;
   logic signed [WEIGHT_W-1:0] mem_rdata;
   rsp_type                    rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCNT_RESET;
         directed_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_ff <= VCNT_W'(csr_wdata);
            CSR_DIRECTED:     directed_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   ame_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ame_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .DEPTH        (DEPTH),
      .AW           (AW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_first_vertex  (req_first_vertex),
      .req_second_vertex (req_second_vertex),
      .req_edge_weight   (req_edge_weight),
      .vertex_count      (vertex_count_ff),
      .directed          (directed_ff),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .mem_raddr         (mem_raddr),
      .mem_rdata         (mem_rdata),
      .rsp_valid         (rsp_valid),
      .rsp               (rsp)
   );

   assign rsp_weight_out   = rsp.weight_out;
   assign rsp_is_adjacent  = rsp.is_adjacent;
   assign rsp_found_vertex = rsp.found_vertex;
   assign rsp_found        = rsp.found;
   assign rsp_edge_count   = rsp.edge_count;
   assign rsp_last_result  = rsp.last_result;

endmodule

[hw/rtl/ame_mem.sv]
// Edge weight memory: one write port, one read port, registered read data.
module ame_mem import ame_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [AW-1:0]              waddr,
   input  logic signed [WEIGHT_W-1:0] wdata,
   input  logic [AW-1:0]              raddr,
   output logic signed [WEIGHT_W-1:0] rdata
);

   logic signed [WEIGHT_W-1:0] mem [DEPTH];
   logic signed [WEIGHT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/ame_ctrl.sv]
// Command sequencer: clearing pass, edge writes, row scans and edge count.
`include "adjacency_matrix_engine_top_defines.svh"
module ame_ctrl import ame_pkg::*; #(
   parameter int MAX_VERTICES = 16,
   parameter int DEPTH        = 256,
   parameter int AW           = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [VTX_W-1:0]           req_first_vertex,
   input  logic signed [SVTX_W-1:0]   req_second_vertex,
   input  logic signed [WEIGHT_W-1:0] req_edge_weight,
   input  logic [VCNT_W-1:0]          vertex_count,
   input  logic                       directed,
   output logic                       mem_we,
   output logic [AW-1:0]              mem_waddr,
   output logic signed [WEIGHT_W-1:0] mem_wdata,
   output logic [AW-1:0]              mem_raddr,
   input  logic signed [WEIGHT_W-1:0] mem_rdata,
   output logic                       rsp_valid,
   output rsp_type                    rsp
);

   localparam int VW   = $clog2(MAX_VERTICES);
   localparam int CW   = VW + 1;
   localparam int CNTW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
      return AW'(int'(r) * MAX_VERTICES + int'(c));
   endfunction

   state_type                  state_ff, state_in;
   logic [AW-1:0]              clr_addr_ff, clr_addr_in;
   cmd_type                    cmd_ff, cmd_in;
   logic [CW-1:0]              src_ff, src_in;
   logic [CW-1:0]              dst_ff, dst_in;
   logic signed [WEIGHT_W-1:0] wt_ff, wt_in;
   logic                       ok_ff, ok_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              row_ff, row_in;
   logic                       pend_ff, pend_in;
   logic [CW-1:0]              pend_idx_ff, pend_idx_in;
   logic                       hold_ff, hold_in;
   logic [CW-1:0]              hold_idx_ff, hold_idx_in;
   logic [RES_CNT_W-1:0]       res_cnt_ff, res_cnt_in;
   logic [CNTW-1:0]            ecnt_ff, ecnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic [CW-1:0]    n;
   logic             src_ok;
   logic             dst_ok;
   logic [VTX_W:0]   scan_start;
   logic [CW-1:0]    req_src;
   logic [CW-1:0]    req_dst;
   logic             hit;
   logic             scan_end;
   logic [CNTW-1:0]  tot;
   logic [CNTW-1:0]  halved;

   always_comb begin
      if (int'(vertex_count) > MAX_VERTICES) begin
         n = CW'(MAX_VERTICES);
      end else begin
         n = CW'(vertex_count);
      end
      src_ok     = int'(req_first_vertex) < int'(n);
      dst_ok     = !req_second_vertex[SVTX_W-1] &&
                   (int'(req_second_vertex[SVTX_W-2:0]) < int'(n));
      scan_start = req_second_vertex[SVTX_W-1] ? '0 :
                   ({1'b0, req_second_vertex[SVTX_W-2:0]} + 1'b1);
      req_src    = CW'(req_first_vertex);
      req_dst    = CW'(req_second_vertex[SVTX_W-2:0]);
      hit        = pend_ff && (mem_rdata > 16'sd0);
      tot        = ecnt_ff + CNTW'(hit);
      halved     = directed ? tot : (tot >> 1);
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cmd_in       = cmd_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      wt_in        = wt_ff;
      ok_in        = ok_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      hold_in      = hold_ff;
      hold_idx_in  = hold_idx_ff;
      res_cnt_in   = res_cnt_ff;
      ecnt_in      = ecnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      mem_we       = 1'b0;
      mem_waddr    = clr_addr_ff;
      mem_wdata    = '0;
      mem_raddr    = '0;
      scan_end     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            pend_in = 1'b0;
            if (start) begin
               src_in = req_src;
               dst_in = req_dst;
               case (cmd_type'(req_command))
                  CMD_ADD, CMD_REMOVE: begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.last_result = 1'b1;
                     if (src_ok && dst_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = cell_addr(req_src, req_dst);
                        mem_wdata = (cmd_type'(req_command) == CMD_ADD) ?
                                    req_edge_weight : '0;
                        wt_in     = mem_wdata;
                        if (!directed) begin
                           state_in = ST_MIRROR;
                        end
                     end
                  end
                  CMD_READ: begin
                     mem_raddr = cell_addr(req_src, req_dst);
                     ok_in     = src_ok && dst_ok;
                     state_in  = ST_READ;
                  end
                  CMD_NEXT, CMD_LIST: begin
                     if (src_ok && ((cmd_type'(req_command) == CMD_LIST) ||
                                    (int'(scan_start) < int'(n)))) begin
                        cmd_in  = cmd_type'(req_command);
                        idx_in  = (cmd_type'(req_command) == CMD_LIST) ?
                                  '0 : CW'(scan_start);
                        mem_raddr   = cell_addr(req_src, idx_in);
                        pend_in     = 1'b1;
                        pend_idx_in = idx_in;
                        idx_in      = idx_in + 1'b1;
                        hold_in     = 1'b0;
                        res_cnt_in  = '0;
                        state_in    = ST_SCAN;
                     end else begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.last_result = 1'b1;
                     end
                  end
                  CMD_COUNT: begin
                     if (n != '0) begin
                        mem_raddr = cell_addr('0, '0);
                        pend_in   = 1'b1;
                        ecnt_in   = '0;
                        if (int'(n) == 1) begin
                           idx_in = '0;
                           row_in = CW'(1);
                        end else begin
                           idx_in = CW'(1);
                           row_in = '0;
                        end
                        state_in = ST_COUNT;
                     end else begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.last_result = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.last_result = 1'b1;
                  end
               endcase
            end
         end

         ST_MIRROR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(dst_ff, src_ff);
            mem_wdata = wt_ff;
            state_in  = ST_IDLE;
         end

         ST_READ: begin
            rsp_valid_in       = 1'b1;
            rsp_in.weight_out  = ok_ff ? mem_rdata : '0;
            rsp_in.is_adjacent = ok_ff && (mem_rdata > 16'sd0);
            rsp_in.last_result = 1'b1;
            state_in           = ST_IDLE;
         end

         ST_SCAN: begin
            scan_end = int'(idx_ff) >= int'(n);
            if (!scan_end) begin
               mem_raddr   = cell_addr(src_ff, idx_ff);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (cmd_ff == CMD_NEXT) begin
               if (hit) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.found_vertex = VTX_W'(pend_idx_ff);
                  rsp_in.found        = 1'b1;
                  rsp_in.last_result  = 1'b1;
                  pend_in             = 1'b0;
                  state_in            = ST_IDLE;
               end else if (scan_end) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.last_result = 1'b1;
                  state_in           = ST_IDLE;
               end
            end else begin
               if (hit) begin
                  if (hold_ff) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.found_vertex = VTX_W'(hold_idx_ff);
                     rsp_in.found        = 1'b1;
                  end
                  hold_in     = 1'b1;
                  hold_idx_in = pend_idx_ff;
                  res_cnt_in  = res_cnt_ff + 1'b1;
                  if ((int'(res_cnt_in) == RESULT_LIMIT) || scan_end) begin
                     pend_in  = 1'b0;
                     state_in = ST_FLUSH;
                  end
               end else if (scan_end) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.found_vertex = VTX_W'(hold_idx_ff);
                  rsp_in.found        = hold_ff;
                  rsp_in.last_result  = 1'b1;
                  if (!hold_ff) begin
                     rsp_in.found_vertex = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            rsp_valid_in        = 1'b1;
            rsp_in.found_vertex = VTX_W'(hold_idx_ff);
            rsp_in.found        = 1'b1;
            rsp_in.last_result  = 1'b1;
            pend_in             = 1'b0;
            state_in            = ST_IDLE;
         end

         ST_COUNT: begin
            ecnt_in = tot;
            if (int'(row_ff) < int'(n)) begin
               mem_raddr = cell_addr(row_ff, idx_ff);
               pend_in   = 1'b1;
               if (int'(idx_ff) + 1 >= int'(n)) begin
                  idx_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               pend_in            = 1'b0;
               rsp_valid_in       = 1'b1;
               rsp_in.last_result = 1'b1;
               if (int'(halved) > COUNT_MAX) begin
                  rsp_in.edge_count = COUNT_W'(COUNT_MAX);
               end else begin
                  rsp_in.edge_count = COUNT_W'(halved);
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         hold_ff      <= 1'b0;
         res_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         hold_ff      <= hold_in;
         res_cnt_ff   <= res_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      wt_ff       <= wt_in;
      ok_ff       <= ok_in;
      idx_ff      <= idx_in;
      row_ff      <= row_in;
      pend_idx_ff <= pend_idx_in;
      hold_idx_ff <= hold_idx_in;
      ecnt_ff     <= ecnt_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `AME_ASSERT_SAME(a_no_beat_in_clear, state_ff == ST_CLEAR, !rsp_valid_ff, "beat during clear")
   `AME_ASSERT_NEXT(a_accept_answered, start && !busy, rsp_valid_ff || busy, "accept lost")
   `AME_ASSERT_SAME(a_no_write_in_scan, state_ff == ST_SCAN || state_ff == ST_COUNT, !mem_we, "write during scan")
   `AME_ASSERT_SAME(a_list_limit, state_ff == ST_SCAN, int'(res_cnt_ff) < RESULT_LIMIT, "list over limit")

endmodule
